// ----- rtl/psfr_pkg.sv -----
// package for the preamble sync frame receiver
// field widths, register indices, reset values, the input word kind and the mode encoding
// no dependencies
package psfr_pkg;

  // word field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 11;
  localparam int unsigned TICK_W   = 16;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_PREAMBLE_VALUE = 2'd0;
  localparam cfg_idx_t REG_PAYLOAD_LENGTH = 2'd1;
  localparam cfg_idx_t REG_TIMEOUT_TICKS  = 2'd2;

  // register reset values
  localparam logic [BYTE_W-1:0] PREAMBLE_RST = 8'hAA;
  localparam logic [LEN_W-1:0]  LENGTH_RST   = 11'd800;
  localparam logic [TICK_W-1:0] TIMEOUT_RST  = 16'd380;

  // input word kind
  typedef logic action_t;
  localparam action_t ACT_BYTE = 1'b0;
  localparam action_t ACT_TICK = 1'b1;

  // receiver mode, one-hot
  typedef enum logic [1:0] {
    MODE_SYNC    = 2'b01,
    MODE_PAYLOAD = 2'b10
  } mode_t;

endpackage

// ----- rtl/psfr_in_if.sv -----
// input channel of the frame receiver: received bytes and ticks
// depends on psfr_pkg
interface psfr_in_if import psfr_pkg::*; ();
  logic              valid;
  logic              ready;
  action_t           action;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output action, output rx_byte, input ready);
  modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

// ----- rtl/psfr_out_if.sv -----
// result channel of the frame receiver: payload bytes, frame end marks and abort marks
// depends on psfr_pkg
interface psfr_out_if import psfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              frame_last;
  logic              frame_abort;

  modport source (output valid, output out_byte, output frame_last, output frame_abort,
                  input ready);
  modport sink   (input valid, input out_byte, input frame_last, input frame_abort,
                  output ready);
endinterface

// ----- rtl/preamble_sync_frame_receiver_unit.sv -----
// a result word is registered and appears in the cycle after the input word that causes it
// throughput: one input word per cycle; the input stalls only while the result
//   register is full and the result side holds ready low
// the mode, preamble, payload and tick counters update in the cycle of accept
// reset (synchronous, rst_n low): sync mode, counters cleared, result register
//   empty, registers back to preamble 0xAA, length 800, timeout 380
module preamble_sync_frame_receiver_unit
  import psfr_pkg::*;
#(
  parameter int unsigned PREAMBLE_LEN = 4,
  parameter int unsigned MAX_PAYLOAD  = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  psfr_in_if.sink               in_ch,
  psfr_out_if.source            out_ch
);

  localparam int unsigned PRE_W  = $clog2(PREAMBLE_LEN + 1);
  localparam int unsigned PCNT_W = $clog2(MAX_PAYLOAD + 1);
  localparam logic [PRE_W-1:0] PRE_LAST = PRE_W'(PREAMBLE_LEN);
  localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(MAX_PAYLOAD);
  localparam logic [LEN_W-1:0] LEN_ONE  = LEN_W'(1);

  // configuration registers
  logic [BYTE_W-1:0] preamble_value_r;
  logic [LEN_W-1:0]  payload_length_r;
  logic [TICK_W-1:0] timeout_ticks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      preamble_value_r <= PREAMBLE_RST;
      payload_length_r <= LENGTH_RST;
      timeout_ticks_r  <= TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PREAMBLE_VALUE: preamble_value_r <= cfg_wdata[BYTE_W-1:0];
        REG_PAYLOAD_LENGTH: payload_length_r <= cfg_wdata[LEN_W-1:0];
        REG_TIMEOUT_TICKS:  timeout_ticks_r  <= cfg_wdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // frame length clamped to 1..MAX_PAYLOAD
  logic [LEN_W-1:0] eff_len;

  always_comb begin
    if (payload_length_r == '0) begin
      eff_len = LEN_ONE;
    end else if (payload_length_r > LEN_MAX) begin
      eff_len = LEN_MAX;
    end else begin
      eff_len = payload_length_r;
    end
  end

  // receiver state
  mode_t              mode_r, mode_nxt;
  logic [PRE_W-1:0]   pre_cnt_r, pre_cnt_nxt;
  logic [PCNT_W-1:0]  pay_cnt_r, pay_cnt_nxt;
  logic [TICK_W-1:0]  tick_cnt_r, tick_cnt_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_abort_r, out_abort_nxt;

  logic              in_acc;
  logic              res_en;
  logic [PRE_W-1:0]  pre_inc;
  logic [PCNT_W-1:0] pay_inc;
  logic [TICK_W-1:0] tick_inc;
  logic              pay_done;
  logic              tick_expired;

  // take a word whenever the result register is free or drains this cycle
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign pre_inc      = pre_cnt_r + PRE_W'(1);
  assign pay_inc      = pay_cnt_r + PCNT_W'(1);
  assign tick_inc     = tick_cnt_r + TICK_W'(1);
  assign pay_done     = LEN_W'(pay_inc) >= eff_len;
  assign tick_expired = (tick_inc >= timeout_ticks_r) || (tick_inc == '0);

  // next state and result for one accepted word
  always_comb begin
    mode_nxt      = mode_r;
    pre_cnt_nxt   = pre_cnt_r;
    pay_cnt_nxt   = pay_cnt_r;
    tick_cnt_nxt  = tick_cnt_r;
    res_en        = 1'b0;
    out_byte_nxt  = in_ch.rx_byte;
    out_last_nxt  = 1'b0;
    out_abort_nxt = 1'b0;
    if (in_acc) begin
      unique case (mode_r)
        MODE_SYNC: begin
          if (in_ch.action == ACT_BYTE) begin
            if (in_ch.rx_byte == preamble_value_r) begin
              if (pre_inc >= PRE_LAST) begin
                mode_nxt     = MODE_PAYLOAD;
                pre_cnt_nxt  = '0;
                pay_cnt_nxt  = '0;
                tick_cnt_nxt = '0;
              end else begin
                pre_cnt_nxt = pre_inc;
              end
            end else begin
              pre_cnt_nxt = '0;
            end
          end
        end
        MODE_PAYLOAD: begin
          res_en = 1'b1;
          if (in_ch.action == ACT_TICK) begin
            out_byte_nxt = '0;
            if (tick_expired) begin
              out_abort_nxt = 1'b1;
              mode_nxt      = MODE_SYNC;
              pre_cnt_nxt   = '0;
              pay_cnt_nxt   = '0;
              tick_cnt_nxt  = '0;
            end else begin
              res_en       = 1'b0;
              tick_cnt_nxt = tick_inc;
            end
          end else if (pay_done) begin
            out_last_nxt = 1'b1;
            mode_nxt     = MODE_SYNC;
            pre_cnt_nxt  = '0;
            pay_cnt_nxt  = '0;
            tick_cnt_nxt = '0;
          end else begin
            pay_cnt_nxt = pay_inc;
          end
        end
        default: begin
          mode_nxt = MODE_SYNC;
        end
      endcase
    end
  end

  // result register valid: set on a new result, cleared when taken
  always_comb begin
    if (res_en) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_SYNC;
      pre_cnt_r   <= '0;
      pay_cnt_r   <= '0;
      tick_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      pre_cnt_r   <= pre_cnt_nxt;
      pay_cnt_r   <= pay_cnt_nxt;
      tick_cnt_r  <= tick_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (res_en) begin
      out_byte_r  <= out_byte_nxt;
      out_last_r  <= out_last_nxt;
      out_abort_r <= out_abort_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.frame_last  = out_last_r;
  assign out_ch.frame_abort = out_abort_r;

  // checks on the receiver control
  a_pre_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    pre_cnt_r < PRE_LAST)
    else $error("preamble count reached the preamble length");

  a_pay_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    LEN_W'(pay_cnt_r) < LEN_MAX)
    else $error("payload count beyond the largest frame");

  a_abort_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_abort_r && out_last_r))
    else $error("result marked both last and abort");

  a_end_to_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (res_en && (out_last_nxt || out_abort_nxt)) |=>
      (mode_r == MODE_SYNC && pre_cnt_r == '0))
    else $error("frame end did not return to sync");

  a_result_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_acc && mode_r == MODE_PAYLOAD))
    else $error("result appeared without an accepted payload word");

endmodule
